### src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the residency cache RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define LREC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define LREC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/lrec_pkg.sv
// ---------------------------------------------------------------------------
// lrec_pkg
// Types and constants shared by the expert residency cache modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lrec_pkg;

   localparam int ID_BITS       = 8;
   localparam int CMD_BITS      = 2;
   localparam int OCC_BITS      = 5;
   localparam int STAT_BITS     = 32;
   localparam int CAP_BITS      = 5;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CAP_BITS-1:0] CAP_RESET        = 5'd16;
   localparam logic                CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_ACCESS  = 2'd0,
      CMD_INSTALL = 2'd1,
      CMD_CLEAR   = 2'd2
   } command_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] command;
      logic [ID_BITS-1:0]  expert_key;
   } req_payload_type;

   typedef struct packed {
      logic                 hit;
      logic                 evicted_valid;
      logic [ID_BITS-1:0]   evicted_id;
      logic [OCC_BITS-1:0]  occupancy;
      logic [STAT_BITS-1:0] hit_count;
      logic [STAT_BITS-1:0] miss_count;
      logic [STAT_BITS-1:0] eviction_count;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic in_range;
      logic below_top;
      logic at_slot;
      logic evict;
   } cell_ctrl_type;

   typedef struct packed {
      logic clear;
      logic bump_hit;
      logic bump_miss;
      logic bump_evict;
   } stat_ctrl_type;

endpackage

`default_nettype wire

### src/lrec_chan_if.sv
// ---------------------------------------------------------------------------
// lrec_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ---------------------------------------------------------------------------
`default_nettype none

interface lrec_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

### src/lrec_cell.sv
// ---------------------------------------------------------------------------
// lrec_cell
// One slot of the recency stack: holds an id, compares it against the probe
// and takes the id of its upper neighbor or the new key when the row updates.
// ---------------------------------------------------------------------------
`default_nettype none

module lrec_cell
   import lrec_pkg::*;
(
   input  logic               clock,
   input  logic [ID_BITS-1:0] probe_id,
   input  logic [ID_BITS-1:0] key_id,
   input  logic [ID_BITS-1:0] next_id,
   input  cell_ctrl_type      ctrl,
   input  logic               found_in,
   output logic [ID_BITS-1:0] id_out,
   output logic               found_out
);

   logic [ID_BITS-1:0] id_ff, id_in;
   logic               match_ff, match_in;
   logic               move;

   always_comb begin
      match_in  = ctrl.capture ? (id_ff == probe_id) : match_ff;
      found_out = found_in | (match_ff & ctrl.in_range);
      move      = ctrl.below_top & (ctrl.evict | found_out);
      id_in     = id_ff;
      if (ctrl.commit) begin
         if (ctrl.at_slot) begin
            id_in = key_id;
         end else if (move) begin
            id_in = next_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      match_ff <= match_in;
   end

   assign id_out = id_ff;

endmodule

`default_nettype wire

### src/lrec_stats.sv
// ---------------------------------------------------------------------------
// lrec_stats
// Saturating hit, miss and eviction counters with a common clear.
// ---------------------------------------------------------------------------
`default_nettype none

module lrec_stats
   import lrec_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  stat_ctrl_type        ctrl,
   output logic [STAT_BITS-1:0] hit_count,
   output logic [STAT_BITS-1:0] miss_count,
   output logic [STAT_BITS-1:0] eviction_count
);

   logic [STAT_BITS-1:0] hit_ff, hit_in;
   logic [STAT_BITS-1:0] miss_ff, miss_in;
   logic [STAT_BITS-1:0] evict_ff, evict_in;

   function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] v);
      sat_inc = (&v) ? v : v + STAT_BITS'(1);
   endfunction

   always_comb begin
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      evict_in = evict_ff;
      if (ctrl.clear) begin
         hit_in   = '0;
         miss_in  = '0;
         evict_in = '0;
      end else begin
         if (ctrl.bump_hit) hit_in = sat_inc(hit_ff);
         if (ctrl.bump_miss) miss_in = sat_inc(miss_ff);
         if (ctrl.bump_evict) evict_in = sat_inc(evict_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff   <= '0;
         miss_ff  <= '0;
         evict_ff <= '0;
      end else begin
         hit_ff   <= hit_in;
         miss_ff  <= miss_in;
         evict_ff <= evict_in;
      end
   end

   assign hit_count      = hit_ff;
   assign miss_count     = miss_ff;
   assign eviction_count = evict_ff;

endmodule

`default_nettype wire

### src/lru_expert_residency_cache_top.sv
// ---------------------------------------------------------------------------
// lru_expert_residency_cache_top: LRU residency cache for expert ids
// The result is registered when the execute state commits, which waits while the
// result channel stalls. A new item is accepted only in the idle state, after the
// compare and update steps of the cell row have finished for the previous item.
// Synchronous reset empties the row, zeroes the counters and sets capacity to 16.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lru_expert_residency_cache_top
   import lrec_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   lrec_chan_if.sink                req_chan,
   lrec_chan_if.source              rsp_chan,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff;
   logic [CAP_BITS-1:0]   capacity_ff;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [CMD_BITS-1:0]   cmd_ff;
   logic [ID_BITS-1:0]    key_ff;
   logic                  rsp_valid_ff;
   logic                  hit_ff;
   logic                  ev_valid_ff;
   logic [ID_BITS-1:0]    ev_id_ff;

   logic                  accept;
   logic                  out_free;
   logic                  commit_go;
   logic                  is_lookup;
   logic                  mutate;
   logic                  hit;
   logic                  evict;
   logic                  csr_write;
   logic [CMP_BITS-1:0]   cap_ext;
   logic [CMP_BITS-1:0]   cap_eff;
   logic [CNT_BITS-1:0]   last_slot;
   logic [MAX_ENTRIES:0]  found;
   logic [ID_BITS-1:0]    cell_id [MAX_ENTRIES];
   stat_ctrl_type         stat_ctrl;
   logic [STAT_BITS-1:0]  hit_count, miss_count, eviction_count;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_CAPACITY);
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS-1] == CSR_IDX_CAPACITY) ?
                       {{(CSR_DATA_BITS-CAP_BITS){1'b0}}, capacity_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_pwdata[CAP_BITS-1:0];
      end
   end

   // clamp capacity into one to the row depth
   always_comb begin
      cap_ext = CMP_BITS'(capacity_ff);
      if (cap_ext == '0) begin
         cap_eff = CMP_BITS'(1);
      end else if (cap_ext > CMP_BITS'(MAX_ENTRIES)) begin
         cap_eff = CMP_BITS'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign commit_go      = (state_ff == S_EXEC) && out_free;
   assign is_lookup      = (cmd_ff == CMD_ACCESS) || (cmd_ff == CMD_INSTALL);
   assign mutate         = commit_go && is_lookup;

   assign found[0]  = 1'b0;
   assign hit       = is_lookup && found[MAX_ENTRIES];
   assign evict     = is_lookup && !found[MAX_ENTRIES] && (CMP_BITS'(cnt_ff) >= cap_eff);
   assign last_slot = (hit || evict) ? cnt_ff - CNT_BITS'(1) : cnt_ff;

   // cell row
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      cell_ctrl_type      ctrl;
      logic [ID_BITS-1:0] next_id;

      assign ctrl.capture   = accept;
      assign ctrl.commit    = mutate;
      assign ctrl.in_range  = CNT_BITS'(i) < cnt_ff;
      assign ctrl.below_top = CNT_BITS'(i + 1) < cnt_ff;
      assign ctrl.at_slot   = CNT_BITS'(i) == last_slot;
      assign ctrl.evict     = evict;

      if (i == MAX_ENTRIES - 1) begin : g_top
         assign next_id = key_ff;
      end else begin : g_mid
         assign next_id = cell_id[i+1];
      end

      lrec_cell u_cell (
         .clock     (clock),
         .probe_id  (req_chan.payload.expert_key),
         .key_id    (key_ff),
         .next_id   (next_id),
         .ctrl      (ctrl),
         .found_in  (found[i]),
         .id_out    (cell_id[i]),
         .found_out (found[i+1])
      );
   end

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (mutate && !hit && !evict && (cnt_ff < CNT_BITS'(MAX_ENTRIES))) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // hold the item for the update step
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.payload.command;
         key_ff <= req_chan.payload.expert_key;
      end
   end

   // counters
   assign stat_ctrl.clear      = commit_go && (cmd_ff == CMD_CLEAR);
   assign stat_ctrl.bump_hit   = mutate && hit;
   assign stat_ctrl.bump_miss  = mutate && !hit && (cmd_ff == CMD_ACCESS);
   assign stat_ctrl.bump_evict = mutate && evict;

   lrec_stats u_stats (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (stat_ctrl),
      .hit_count      (hit_count),
      .miss_count     (miss_count),
      .eviction_count (eviction_count)
   );

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (commit_go) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (commit_go) begin
         hit_ff      <= hit;
         ev_valid_ff <= evict;
         ev_id_ff    <= evict ? cell_id[0] : '0;
      end
   end

   // state changes only when a result is loaded, so counters read live
   assign rsp_chan.valid                  = rsp_valid_ff;
   assign rsp_chan.payload.hit            = hit_ff;
   assign rsp_chan.payload.evicted_valid  = ev_valid_ff;
   assign rsp_chan.payload.evicted_id     = ev_id_ff;
   assign rsp_chan.payload.occupancy      = OCC_BITS'(cnt_ff);
   assign rsp_chan.payload.hit_count      = hit_count;
   assign rsp_chan.payload.miss_count     = miss_count;
   assign rsp_chan.payload.eviction_count = eviction_count;

   `LREC_ASSERT(a_occ_bound, clock, reset, cnt_ff <= CNT_BITS'(MAX_ENTRIES), "occupancy above row depth")
   `LREC_ASSERT(a_hit_no_evict, clock, reset, !(rsp_valid_ff && hit_ff && ev_valid_ff), "hit and eviction together")
   `LREC_ASSERT(a_evid_zero, clock, reset, !rsp_valid_ff || ev_valid_ff || (ev_id_ff == '0), "evicted id without eviction")
   `LREC_ASSERT_NEXT(a_hit_keeps_occ, clock, reset, mutate && hit, cnt_ff == $past(cnt_ff), "hit changed occupancy")
   `LREC_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_chan.ready, "item accepted during update")

endmodule

`default_nettype wire

### sim/lru_residency_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lru_residency_checker
// Watches the request, result and register ports of the expert residency
// cache. Keeps its own recency stack, capacity copy and counters, predicts
// one result per accepted request and compares each result field by field
// against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_residency_checker
   import lrec_pkg::*;
#(
   parameter int MAX_SLOTS = 16
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  req_payload_type          req_item,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  rsp_payload_type          rsp_item,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output int                       mismatch_count,
   output int                       results_owed
);

   logic [CAP_BITS-1:0]  capacity_reg;
   logic [ID_BITS-1:0]   recency_stack [MAX_SLOTS];
   int                   resident;
   logic [STAT_BITS-1:0] hits_seen;
   logic [STAT_BITS-1:0] misses_seen;
   logic [STAT_BITS-1:0] evictions_seen;
   rsp_payload_type      owed_results [$];

   function automatic logic [STAT_BITS-1:0] bump(input logic [STAT_BITS-1:0] value);
      return (value == '1) ? value : value + 1'b1;
   endfunction

   task automatic track_lookup(input req_payload_type item, output rsp_payload_type res);
      int  limit;
      int  slot;
      int  i;
      bit  found;
      res   = '0;
      limit = int'(capacity_reg);
      if (limit < 1) limit = 1;
      if (limit > MAX_SLOTS) limit = MAX_SLOTS;
      case (item.command)
         CMD_CLEAR: begin
            hits_seen      = '0;
            misses_seen    = '0;
            evictions_seen = '0;
         end
         CMD_ACCESS, CMD_INSTALL: begin
            found = 1'b0;
            slot  = 0;
            for (i = 0; i < resident; i++) begin
               if (!found && recency_stack[i] == item.expert_key) begin
                  found = 1'b1;
                  slot  = i;
               end
            end
            if (found) begin
               res.hit   = 1'b1;
               hits_seen = bump(hits_seen);
               for (i = slot; i + 1 < resident; i++) recency_stack[i] = recency_stack[i + 1];
               recency_stack[resident - 1] = item.expert_key;
            end else begin
               if (item.command == CMD_ACCESS) misses_seen = bump(misses_seen);
               if (resident >= limit && resident > 0) begin
                  res.evicted_valid = 1'b1;
                  res.evicted_id    = recency_stack[0];
                  for (i = 0; i + 1 < resident; i++) recency_stack[i] = recency_stack[i + 1];
                  resident--;
                  evictions_seen = bump(evictions_seen);
               end
               if (resident < MAX_SLOTS) begin
                  recency_stack[resident] = item.expert_key;
                  resident++;
               end
            end
         end
         default: begin
         end
      endcase
      res.occupancy      = OCC_BITS'(resident);
      res.hit_count      = hits_seen;
      res.miss_count     = misses_seen;
      res.eviction_count = evictions_seen;
   endtask

   task automatic compare_field(input string name, input logic [STAT_BITS-1:0] want,
                                input logic [STAT_BITS-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_payload_type predicted;
      if (reset) begin
         capacity_reg   = CAP_RESET;
         resident       = 0;
         hits_seen      = '0;
         misses_seen    = '0;
         evictions_seen = '0;
         owed_results.delete();
         mismatch_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_CAPACITY)
            capacity_reg = csr_pwdata[CAP_BITS-1:0];
         if (req_valid && req_ready) begin
            track_lookup(req_item, predicted);
            owed_results.insert(owed_results.size(), predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result item with no request outstanding");
               mismatch_count++;
            end else begin
               predicted = owed_results[0];
               owed_results.delete(0);
               compare_field("hit", predicted.hit, rsp_item.hit);
               compare_field("evicted_valid", predicted.evicted_valid, rsp_item.evicted_valid);
               compare_field("evicted_id", predicted.evicted_id, rsp_item.evicted_id);
               compare_field("occupancy", predicted.occupancy, rsp_item.occupancy);
               compare_field("hit_count", predicted.hit_count, rsp_item.hit_count);
               compare_field("miss_count", predicted.miss_count, rsp_item.miss_count);
               compare_field("eviction_count", predicted.eviction_count,
                             rsp_item.eviction_count);
            end
         end
      end
      results_owed = owed_results.size();
   end

endmodule

`default_nettype wire

### sim/tb_lru_expert_residency_cache_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_lru_expert_residency_cache_top
// Drives directed and random expert lookups, installs and clears through the
// request channel under several capacity settings and idle patterns, holds
// the result channel off for a long stretch once, and reports the verdict
// from the checker's mismatch count, or errors when traffic stalls too long.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_lru_expert_residency_cache_top
   import lrec_pkg::*;
();

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 7;
   localparam int PHASE_ITEMS = 96;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   int                       mismatch_count;
   int                       results_owed;
   int                       send_idle_pct;
   int                       recv_stall_pct = 0;
   logic                     long_hold_req  = 1'b0;
   logic [ID_BITS-1:0]       id_base;
   int                       quiet_cycles;

   lrec_chan_if #(.payload_type(req_payload_type)) req_chan ();
   lrec_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   lru_expert_residency_cache_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   lru_residency_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_item       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_item       (rsp_chan.payload),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_lru_expert_residency_cache_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int hold_left;
      bit hold_done;
      hold_left      = 0;
      hold_done      = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            hold_left = 150;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   task automatic offer_item(input command_type cmd, input logic [ID_BITS-1:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= {cmd, id};
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_IDX_CAPACITY, 2'b00};
      csr_pwdata  <= CSR_DATA_BITS'(cap);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic command_type pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 55) return CMD_ACCESS;
      if (r < 96) return CMD_INSTALL;
      return CMD_CLEAR;
   endfunction

   function automatic logic [ID_BITS-1:0] pick_id(input int cap);
      logic [ID_BITS-1:0] id;
      if ($urandom_range(99) < 78) id = id_base + ID_BITS'($urandom_range(cap + 2));
      else id = ID_BITS'($urandom_range(255));
      return id;
   endfunction

   initial begin : stimulus
      int ph;
      int cap;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      send_idle_pct    = 0;
      id_base          = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_capacity(5'd4);
      offer_item(CMD_ACCESS, 8'd0);
      offer_item(CMD_ACCESS, 8'd255);
      offer_item(CMD_INSTALL, 8'd10);
      offer_item(CMD_INSTALL, 8'd0);
      offer_item(CMD_ACCESS, 8'd255);
      offer_item(CMD_ACCESS, 8'd20);
      offer_item(CMD_ACCESS, 8'd30);
      offer_item(CMD_INSTALL, 8'd40);
      offer_item(CMD_CLEAR, 8'd255);
      offer_item(CMD_ACCESS, 8'd30);
      offer_item(CMD_ACCESS, 8'd170);
      // shrink below occupancy: each miss evicts one and refills
      drain_results();
      write_capacity(5'd2);
      offer_item(CMD_ACCESS, 8'd50);
      offer_item(CMD_ACCESS, 8'd30);
      offer_item(CMD_INSTALL, 8'd60);
      offer_item(CMD_INSTALL, 8'd85);
      drain_results();
      write_capacity(5'd1);
      offer_item(CMD_ACCESS, 8'd70);
      offer_item(CMD_ACCESS, 8'd70);
      offer_item(CMD_CLEAR, 8'd0);
      offer_item(CMD_INSTALL, 8'd1);

      for (ph = 0; ph < PHASES; ph++) begin
         drain_results();
         case (ph)
            0: begin cap = 16; send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin cap = 1;  send_idle_pct = 62; recv_stall_pct <= 0;  end
            2: begin cap = 8;  send_idle_pct = 0;  recv_stall_pct <= 62; end
            3: begin cap = $urandom_range(15, 2); send_idle_pct = 23; recv_stall_pct <= 23; end
            4: begin cap = 16; send_idle_pct = 62; recv_stall_pct <= 0;  end
            5: begin cap = 2;  send_idle_pct = 0;  recv_stall_pct <= 0;  end
            default: begin cap = 16; send_idle_pct = 23; recv_stall_pct <= 23; end
         endcase
         long_hold_req <= (ph == 0);
         write_capacity(CAP_BITS'(cap));
         id_base = ID_BITS'($urandom_range(255));
         repeat (PHASE_ITEMS) offer_item(pick_command(), pick_id(cap));
      end

      drain_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_lru_expert_residency_cache_top: done, clean");
      end else begin
         $display("tb_lru_expert_residency_cache_top: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
+incdir+src
src/lrec_pkg.sv
src/lrec_chan_if.sv
src/lrec_cell.sv
src/lrec_stats.sv
src/lru_expert_residency_cache_top.sv
sim/lru_residency_checker.sv
sim/tb_lru_expert_residency_cache_top.sv
